// File: rtl/bnms_pkg.sv
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared constants for the box non-maximum suppression block: field widths,
// box word layout, multiplier operand widths and sequencer state codes.
// ----------------------------------------------------------------------------
package bnms_pkg;

   // defaults for the top level parameters
   localparam int DEF_MAX_BOXES  = 64;
   localparam int DEF_COORD_BITS = 16;

   // fixed field widths
   localparam int IO_COORD_BITS = 16;
   localparam int DIM_BITS      = 15;
   localparam int SCORE_BITS    = 16;
   localparam int CLS_BITS      = 8;
   localparam int THR_BITS      = 8;
   localparam int AREA_BITS     = 32;
   localparam int OVL_BITS      = 16;
   localparam int UNI_BITS      = 34;

   // box word layout, low part (coordinates sit above, width set by COORD_BITS)
   localparam int AREA_LO  = 0;
   localparam int CLS_LO   = AREA_LO + AREA_BITS;
   localparam int SCORE_LO = CLS_LO + CLS_BITS;
   localparam int H_LO     = SCORE_LO + SCORE_BITS;
   localparam int W_LO     = H_LO + DIM_BITS;
   localparam int Y_LO     = W_LO + DIM_BITS;

   // shared multiplier
   localparam int MUL_A_BITS = 32;
   localparam int MUL_B_BITS = 16;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

   localparam logic [THR_BITS-1:0] THR_RESET = 8'd128;

   // sequencer states
   localparam int ST_BITS = 4;
   localparam logic [ST_BITS-1:0] ST_IDLE   = 4'd0;
   localparam logic [ST_BITS-1:0] ST_LD_MUL = 4'd1;
   localparam logic [ST_BITS-1:0] ST_LD_CHK = 4'd2;
   localparam logic [ST_BITS-1:0] ST_LD_CMP = 4'd3;
   localparam logic [ST_BITS-1:0] ST_LD_PUT = 4'd4;
   localparam logic [ST_BITS-1:0] ST_N_RDA  = 4'd5;
   localparam logic [ST_BITS-1:0] ST_N_LDA  = 4'd6;
   localparam logic [ST_BITS-1:0] ST_N_LDB  = 4'd7;
   localparam logic [ST_BITS-1:0] ST_N_INT  = 4'd8;
   localparam logic [ST_BITS-1:0] ST_N_UNI  = 4'd9;
   localparam logic [ST_BITS-1:0] ST_N_THR  = 4'd10;
   localparam logic [ST_BITS-1:0] ST_N_CMP  = 4'd11;
   localparam logic [ST_BITS-1:0] ST_O_RD   = 4'd12;
   localparam logic [ST_BITS-1:0] ST_O_SHOW = 4'd13;
   localparam logic [ST_BITS-1:0] ST_O_WAIT = 4'd14;

endpackage

// File: rtl/bnms_ram.sv
// ----------------------------------------------------------------------------
// bnms_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/bnms_mul.sv
// ----------------------------------------------------------------------------
// bnms_mul
// Shared unsigned multiplier with a registered product, used for box areas,
// overlap areas and the threshold times union product.
// ----------------------------------------------------------------------------
module bnms_mul
   import bnms_pkg::*;
(
   input  logic                  clock,
   input  logic [MUL_A_BITS-1:0] op_a,
   input  logic [MUL_B_BITS-1:0] op_b,
   output logic [MUL_P_BITS-1:0] prod
);

   logic [MUL_P_BITS-1:0] prod_ff;

   // register the product
   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_BITS'(op_a) * MUL_P_BITS'(op_b);
   end

   assign prod = prod_ff;

endmodule

// File: rtl/box_non_max_suppression.sv
// ----------------------------------------------------------------------------
// box_non_max_suppression
// Class-agnostic greedy non-maximum suppression. Boxes are kept in a RAM in
// descending score order; on the last box each surviving box suppresses the
// later boxes whose IoU exceeds the threshold, and survivors are sent out.
//
//   channel | direction | handshake          | word
//   req_    | in        | req_valid/req_stall | one box, last_box ends the set
//   rsp_    | out       | rsp_valid/rsp_stall | one surviving box, out_last
//   csr_    | in        | csr_valid/csr_ready | IoU threshold, 1/256 units
//
// Loading a box works out its area, then shifts each stored box of lower score
// up one place and writes the new box in. The suppression pass takes each box
// pair through the shared multiplier, skipping suppressed outer boxes.
// Output holds each survivor until it is taken and skips suppressed boxes.
// Reset clears the count, mask and state and sets the threshold to 128.
// req_stall is high whenever the sequencer is not idle.
// ----------------------------------------------------------------------------
module box_non_max_suppression
   import bnms_pkg::*;
#(
   parameter int MAX_BOXES  = DEF_MAX_BOXES,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   // input boxes
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [IO_COORD_BITS-1:0] req_box_x,
   input  logic signed [IO_COORD_BITS-1:0] req_box_y,
   input  logic [DIM_BITS-1:0]         req_box_width,
   input  logic [DIM_BITS-1:0]         req_box_height,
   input  logic [SCORE_BITS-1:0]       req_box_score,
   input  logic [CLS_BITS-1:0]         req_box_class,
   input  logic                        req_last_box,
   // surviving boxes
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [IO_COORD_BITS-1:0] rsp_out_x,
   output logic signed [IO_COORD_BITS-1:0] rsp_out_y,
   output logic [DIM_BITS-1:0]         rsp_out_width,
   output logic [DIM_BITS-1:0]         rsp_out_height,
   output logic [SCORE_BITS-1:0]       rsp_out_score,
   output logic [CLS_BITS-1:0]         rsp_out_class,
   output logic                        rsp_out_last,
   // threshold register
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [THR_BITS-1:0]         csr_iou_threshold
);

   localparam int CW    = COORD_BITS;
   localparam int IDXW  = $clog2(MAX_BOXES);
   localparam int CNTW  = $clog2(MAX_BOXES + 1);
   localparam int X_LO  = Y_LO + CW;
   localparam int WW    = X_LO + CW;
   localparam int GW    = ((CW > DIM_BITS) ? CW : DIM_BITS) + 3;

   // state
   logic [ST_BITS-1:0]   state_ff, state_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [CNTW-1:0]      i_ff, i_in;
   logic [CNTW-1:0]      j_ff, j_in;
   logic [CNTW-1:0]      k_ff, k_in;
   logic [MAX_BOXES-1:0] mask_ff, mask_in;
   logic [THR_BITS-1:0]  thr_ff;
   logic                 last_ff, last_in;
   logic [WW-1:0]        new_ff, new_in;
   logic [WW-1:0]        a_word_ff, a_word_in;
   logic [AREA_BITS-1:0] b_area_ff, b_area_in;
   logic [OVL_BITS-1:0]  iw_ff, iw_in, ih_ff, ih_in;
   logic [AREA_BITS-1:0] inter_ff, inter_in;
   logic signed [UNI_BITS-1:0] uni_ff, uni_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [WW-1:0]        rsp_word_ff, rsp_word_in;

   // RAM and multiplier hookup
   logic                 wr_en;
   logic [IDXW-1:0]      wr_addr;
   logic [WW-1:0]        wr_data;
   logic [IDXW-1:0]      rd_addr;
   logic [WW-1:0]        rd_data;
   logic [MUL_A_BITS-1:0] mul_a;
   logic [MUL_B_BITS-1:0] mul_b;
   logic [MUL_P_BITS-1:0] prod;

   // geometry
   logic signed [CW-1:0] ax, ay, bx, by;
   logic signed [GW-1:0] axs, ays, bxs, bys, aex, aey, bex, bey, ix, iy;
   logic                 later;
   logic                 supp;

   bnms_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_BOXES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bnms_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // overlap widths between held box A and the box just read
   always_comb begin
      ax  = a_word_ff[X_LO +: CW];
      ay  = a_word_ff[Y_LO +: CW];
      bx  = rd_data[X_LO +: CW];
      by  = rd_data[Y_LO +: CW];
      axs = GW'(ax);
      ays = GW'(ay);
      bxs = GW'(bx);
      bys = GW'(by);
      aex = axs + GW'(a_word_ff[W_LO +: DIM_BITS]);
      aey = ays + GW'(a_word_ff[H_LO +: DIM_BITS]);
      bex = bxs + GW'(rd_data[W_LO +: DIM_BITS]);
      bey = bys + GW'(rd_data[H_LO +: DIM_BITS]);
      ix  = ((aex < bex) ? aex : bex) - ((axs > bxs) ? axs : bxs) + GW'(1);
      iy  = ((aey < bey) ? aey : bey) - ((ays > bys) ? ays : bys) + GW'(1);
      iw_in = ix[GW-1] ? '0 : ix[OVL_BITS-1:0];
      ih_in = iy[GW-1] ? '0 : iy[OVL_BITS-1:0];
   end

   // suppression decision from union and threshold product
   always_comb begin
      if (uni_ff > 0) begin
         supp = (MUL_P_BITS'({inter_ff, 8'd0}) > prod);
      end else if (uni_ff == 0) begin
         supp = (inter_ff != '0);
      end else begin
         supp = 1'b0;
      end
   end

   // any survivor ranked after i
   always_comb begin
      later = 1'b0;
      for (int n = 0; n < MAX_BOXES; n++) begin
         if ((CNTW'(n) > i_ff) && (CNTW'(n) < cnt_ff) && !mask_ff[n]) begin
            later = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      mask_in      = mask_ff;
      last_in      = last_ff;
      new_in       = new_ff;
      a_word_in    = a_word_ff;
      b_area_in    = b_area_ff;
      inter_in     = inter_ff;
      uni_in       = uni_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      wr_addr      = k_ff[IDXW-1:0];
      wr_data      = new_ff;
      rd_addr      = '0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               new_in = {CW'($unsigned(req_box_x)), CW'($unsigned(req_box_y)),
                         req_box_width, req_box_height, req_box_score,
                         req_box_class, AREA_BITS'(0)};
               last_in = req_last_box;
               if (cnt_ff < CNTW'(MAX_BOXES)) begin
                  state_in = ST_LD_MUL;
               end else if (req_last_box) begin
                  i_in     = '0;
                  mask_in  = '0;
                  state_in = ST_N_RDA;
               end
            end
         end
         ST_LD_MUL: begin
            mul_a    = MUL_A_BITS'(new_ff[W_LO +: DIM_BITS]);
            mul_b    = MUL_B_BITS'(new_ff[H_LO +: DIM_BITS]);
            state_in = ST_LD_CHK;
         end
         ST_LD_CHK: begin
            new_in[AREA_LO +: AREA_BITS] = prod[AREA_BITS-1:0];
            k_in = cnt_ff;
            if (cnt_ff == '0) begin
               state_in = ST_LD_PUT;
            end else begin
               rd_addr  = IDXW'(cnt_ff - CNTW'(1));
               state_in = ST_LD_CMP;
            end
         end
         ST_LD_CMP: begin
            // shift a lower score up one place, or drop the new box in
            wr_en = 1'b1;
            if (rd_data[SCORE_LO +: SCORE_BITS] < new_ff[SCORE_LO +: SCORE_BITS]) begin
               wr_data = rd_data;
               k_in    = k_ff - CNTW'(1);
               if (k_ff == CNTW'(1)) begin
                  state_in = ST_LD_PUT;
               end else begin
                  rd_addr = IDXW'(k_ff - CNTW'(2));
               end
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
               if (last_ff) begin
                  i_in     = '0;
                  mask_in  = '0;
                  state_in = ST_N_RDA;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LD_PUT: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + CNTW'(1);
            if (last_ff) begin
               i_in     = '0;
               mask_in  = '0;
               state_in = ST_N_RDA;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_N_RDA: begin
            if (i_ff == cnt_ff) begin
               i_in     = '0;
               state_in = ST_O_RD;
            end else if (mask_ff[i_ff[IDXW-1:0]]) begin
               i_in = i_ff + CNTW'(1);
            end else begin
               rd_addr  = i_ff[IDXW-1:0];
               state_in = ST_N_LDA;
            end
         end
         ST_N_LDA: begin
            a_word_in = rd_data;
            j_in      = i_ff + CNTW'(1);
            if (i_ff + CNTW'(1) == cnt_ff) begin
               i_in     = i_ff + CNTW'(1);
               state_in = ST_N_RDA;
            end else begin
               rd_addr  = IDXW'(i_ff + CNTW'(1));
               state_in = ST_N_LDB;
            end
         end
         ST_N_LDB: begin
            b_area_in = rd_data[AREA_LO +: AREA_BITS];
            state_in  = ST_N_INT;
         end
         ST_N_INT: begin
            mul_a    = MUL_A_BITS'(iw_ff);
            mul_b    = ih_ff;
            state_in = ST_N_UNI;
         end
         ST_N_UNI: begin
            inter_in = prod[AREA_BITS-1:0];
            uni_in   = UNI_BITS'(a_word_ff[AREA_LO +: AREA_BITS]) + UNI_BITS'(b_area_ff)
                     - UNI_BITS'(prod[AREA_BITS-1:0]);
            state_in = ST_N_THR;
         end
         ST_N_THR: begin
            mul_a    = uni_ff[MUL_A_BITS-1:0];
            mul_b    = MUL_B_BITS'(thr_ff);
            state_in = ST_N_CMP;
         end
         ST_N_CMP: begin
            if (supp) begin
               mask_in[j_ff[IDXW-1:0]] = 1'b1;
            end
            j_in = j_ff + CNTW'(1);
            if (j_ff + CNTW'(1) == cnt_ff) begin
               i_in     = i_ff + CNTW'(1);
               state_in = ST_N_RDA;
            end else begin
               rd_addr  = IDXW'(j_ff + CNTW'(1));
               state_in = ST_N_LDB;
            end
         end
         ST_O_RD: begin
            if (i_ff == cnt_ff) begin
               cnt_in   = '0;
               mask_in  = '0;
               state_in = ST_IDLE;
            end else if (mask_ff[i_ff[IDXW-1:0]]) begin
               i_in = i_ff + CNTW'(1);
            end else begin
               rd_addr  = i_ff[IDXW-1:0];
               state_in = ST_O_SHOW;
            end
         end
         ST_O_SHOW: begin
            rsp_word_in  = rd_data;
            rsp_last_in  = !later;
            rsp_valid_in = 1'b1;
            state_in     = ST_O_WAIT;
         end
         ST_O_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               i_in         = i_ff + CNTW'(1);
               state_in     = ST_O_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         mask_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         mask_ff      <= mask_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_iou_threshold;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      new_ff      <= new_in;
      a_word_ff   <= a_word_in;
      b_area_ff   <= b_area_in;
      iw_ff       <= iw_in;
      ih_ff       <= ih_in;
      inter_ff    <= inter_in;
      uni_ff      <= uni_in;
      rsp_last_ff <= rsp_last_in;
      rsp_word_ff <= rsp_word_in;
   end

   // result word
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = IO_COORD_BITS'(rsp_word_ff[X_LO +: CW]);
   assign rsp_out_y      = IO_COORD_BITS'(rsp_word_ff[Y_LO +: CW]);
   assign rsp_out_width  = rsp_word_ff[W_LO +: DIM_BITS];
   assign rsp_out_height = rsp_word_ff[H_LO +: DIM_BITS];
   assign rsp_out_score  = rsp_word_ff[SCORE_LO +: SCORE_BITS];
   assign rsp_out_class  = rsp_word_ff[CLS_LO +: CLS_BITS];
   assign rsp_out_last   = rsp_last_ff;

   // checks
   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_O_WAIT))
      else $error("result word shown outside the output wait state");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(MAX_BOXES))
      else $error("box count beyond capacity");

   a_drop_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall) |=> !rsp_valid_ff)
      else $error("result word repeated after it was taken");

   a_idle_empty_mask: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (mask_ff == '0))
      else $error("suppression mask left set between sets");

endmodule

// File: verif/nms_checker.sv
// ----------------------------------------------------------------------------
// nms_checker
// Watches the box, survivor and threshold channels of the suppression block.
// It keeps its own copy of the box store, ranking and threshold, and on each
// last box it works out the survivors of the set in rank order. Each
// survivor word that leaves the block is compared with the oldest one due.
// ----------------------------------------------------------------------------
module nms_checker
   import bnms_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic signed [IO_COORD_BITS-1:0] req_box_x,
   input  logic signed [IO_COORD_BITS-1:0] req_box_y,
   input  logic [DIM_BITS-1:0]             req_box_width,
   input  logic [DIM_BITS-1:0]             req_box_height,
   input  logic [SCORE_BITS-1:0]           req_box_score,
   input  logic [CLS_BITS-1:0]             req_box_class,
   input  logic                            req_last_box,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic signed [IO_COORD_BITS-1:0] rsp_out_x,
   input  logic signed [IO_COORD_BITS-1:0] rsp_out_y,
   input  logic [DIM_BITS-1:0]             rsp_out_width,
   input  logic [DIM_BITS-1:0]             rsp_out_height,
   input  logic [SCORE_BITS-1:0]           rsp_out_score,
   input  logic [CLS_BITS-1:0]             rsp_out_class,
   input  logic                            rsp_out_last,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [THR_BITS-1:0]             csr_iou_threshold,
   output int                              fail_count,
   output int                              survivors_due,
   output int                              survivors_seen
);

   localparam int CAPACITY = DEF_MAX_BOXES;

   typedef struct packed {
      logic signed [IO_COORD_BITS-1:0] x;
      logic signed [IO_COORD_BITS-1:0] y;
      logic [DIM_BITS-1:0]             w;
      logic [DIM_BITS-1:0]             h;
      logic [SCORE_BITS-1:0]           score;
      logic [CLS_BITS-1:0]             cls;
      logic                            last;
   } box_word_type;

   box_word_type      held_box [CAPACITY];
   int                score_rank [CAPACITY];
   int                held_count;
   logic [THR_BITS-1:0] iou_thr;
   box_word_type      survivor_q [$];

   // decide whether box b is knocked out by the higher-ranked box a
   function automatic bit knocks_out(box_word_type a, box_word_type b,
                                     logic [THR_BITS-1:0] thr);
      longint ax, ay, bx, by, aw, ah, bw, bh, iw, ih, inter, uni;
      ax = longint'(a.x); ay = longint'(a.y); bx = longint'(b.x); by = longint'(b.y);
      aw = longint'(a.w); ah = longint'(a.h); bw = longint'(b.w); bh = longint'(b.h);
      iw = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - ((ax > bx) ? ax : bx) + 1;
      ih = ((ay + ah < by + bh) ? ay + ah : by + bh) - ((ay > by) ? ay : by) + 1;
      if (iw < 0) iw = 0;
      if (ih < 0) ih = 0;
      inter = iw * ih;
      uni = aw * ah + bw * bh - inter;
      if (uni > 0) return inter * 256 > longint'(thr) * uni;
      if (uni == 0) return inter > 0;
      return 0;
   endfunction

   // greedy pass over the ranking, then queue the survivors in rank order
   task automatic suppress_set();
      bit dead [CAPACITY];
      int n_out;
      n_out = 0;
      for (int i = 0; i < CAPACITY; i++) dead[i] = 0;
      for (int i = 0; i < held_count; i++) begin
         if (!dead[i]) begin
            for (int j = i + 1; j < held_count; j++)
               if (knocks_out(held_box[score_rank[i]], held_box[score_rank[j]], iou_thr))
                  dead[j] = 1;
         end
      end
      for (int i = 0; i < held_count; i++) begin
         if (!dead[i]) begin
            box_word_type b;
            b = held_box[score_rank[i]];
            b.last = 0;
            survivor_q = {survivor_q, b};
            n_out++;
         end
      end
      if (n_out > 0) survivor_q[survivor_q.size() - 1].last = 1;
      held_count = 0;
   endtask

   always @(posedge clock) begin
      box_word_type got, want;
      int k;
      if (reset) begin
         held_count = 0;
         iou_thr = THR_RESET;
         survivor_q.delete();
         fail_count = 0;
         survivors_seen = 0;
      end else begin
         // pick up a threshold write
         if (csr_valid && csr_ready) iou_thr = csr_iou_threshold;

         // compare a survivor word with the oldest one due
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_x, rsp_out_y, rsp_out_width, rsp_out_height,
                    rsp_out_score, rsp_out_class, rsp_out_last};
            survivors_seen++;
            if (survivor_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: survivor word with none due: x=%0d y=%0d w=%0d h=%0d",
                           got.x, got.y, got.w, got.h);
            end else begin
               want = survivor_q.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
                   got.h !== want.h || got.score !== want.score ||
                   got.cls !== want.cls || got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"ERROR: survivor mismatch\n  want x=%0d y=%0d w=%0d h=%0d ",
                               "score=%0d class=%0d last=%0b\n  got  x=%0d y=%0d w=%0d ",
                               "h=%0d score=%0d class=%0d last=%0b"},
                              want.x, want.y, want.w, want.h, want.score, want.cls,
                              want.last, got.x, got.y, got.w, got.h, got.score,
                              got.cls, got.last);
               end
            end
         end

         // store an incoming box, keeping the ranking stable on equal scores
         if (req_valid && !req_stall) begin
            if (held_count < CAPACITY) begin
               held_box[held_count] = '{req_box_x, req_box_y, req_box_width,
                                        req_box_height, req_box_score,
                                        req_box_class, 1'b0};
               k = held_count;
               while (k > 0 && held_box[score_rank[k-1]].score < req_box_score) begin
                  score_rank[k] = score_rank[k-1];
                  k--;
               end
               score_rank[k] = held_count;
               held_count++;
            end
            if (req_last_box) suppress_set();
         end
      end
      survivors_due = survivor_q.size();
   end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives boxes and threshold writes into the suppression block under four
// idling modes, with directed corner sets, clustered random sets, an
// over-capacity set and a long receiver hold. The checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;
   import bnms_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int SETTLE      = 300;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic signed [IO_COORD_BITS-1:0] req_box_x;
   logic signed [IO_COORD_BITS-1:0] req_box_y;
   logic [DIM_BITS-1:0]             req_box_width;
   logic [DIM_BITS-1:0]             req_box_height;
   logic [SCORE_BITS-1:0]           req_box_score;
   logic [CLS_BITS-1:0]             req_box_class;
   logic                            req_last_box;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic signed [IO_COORD_BITS-1:0] rsp_out_x;
   logic signed [IO_COORD_BITS-1:0] rsp_out_y;
   logic [DIM_BITS-1:0]             rsp_out_width;
   logic [DIM_BITS-1:0]             rsp_out_height;
   logic [SCORE_BITS-1:0]           rsp_out_score;
   logic [CLS_BITS-1:0]             rsp_out_class;
   logic                            rsp_out_last;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [THR_BITS-1:0]             csr_iou_threshold;

   int fail_count, survivors_due, survivors_seen;
   int idle_pct, stall_pct;
   int boxes_sent, sets_sent;
   int hold_ticket, hold_seen, hold_left;
   longint cycles;

   box_non_max_suppression dut (.*);

   nms_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // guard against a hang
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus a long hold whenever one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= 400;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // offer one box word, with random idle cycles ahead of it
   task automatic send_box(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic [14:0] w, input logic [14:0] h,
                           input logic [15:0] score, input logic [7:0] cls,
                           input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid      <= 1;
      req_box_x      <= x;
      req_box_y      <= y;
      req_box_width  <= w;
      req_box_height <= h;
      req_box_score  <= score;
      req_box_class  <= cls;
      req_last_box   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      boxes_sent++;
      if (last) sets_sent++;
   endtask

   // hold the sender until every survivor due has come out
   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (survivors_due != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [7:0] thr);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_valid         <= 1;
      csr_iou_threshold <= thr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // a set of n boxes: mostly clustered so boxes overlap, some full-range noise
   task automatic send_set(input int n);
      int cx, cy, spread;
      logic signed [15:0] x, y;
      logic [14:0] w, h;
      logic [15:0] score;
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
      spread = ($urandom_range(0, 3) == 0) ? 400 : 40;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            x = 16'($urandom); y = 16'($urandom);
            w = 15'($urandom); h = 15'($urandom);
         end else begin
            x = 16'(cx + int'($urandom_range(0, spread)));
            y = 16'(cy + int'($urandom_range(0, spread)));
            w = 15'($urandom_range(0, spread + 20));
            h = 15'($urandom_range(0, spread + 20));
         end
         score = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
         send_box(x, y, w, h, score, 8'($urandom), i == n - 1);
      end
   endtask

   initial begin
      req_valid = 0; req_box_x = 0; req_box_y = 0; req_box_width = 0;
      req_box_height = 0; req_box_score = 0; req_box_class = 0; req_last_box = 0;
      csr_valid = 0; csr_iou_threshold = 0;
      idle_pct = 0; stall_pct = 0;
      boxes_sent = 0; sets_sent = 0; hold_ticket = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: lone box at the field extremes
      send_box(-16'sd32768, 16'sd32767, 15'd32767, 15'd0, 16'hFFFF, 8'hFF, 1);
      // equal scores and identical boxes: a higher-scored overlapping box knocks out both
      send_box(16'sd10, 16'sd10, 15'd20, 15'd20, 16'd500, 8'd1, 0);
      send_box(16'sd10, 16'sd10, 15'd20, 15'd20, 16'd500, 8'd2, 0);
      send_box(16'sd15, 16'sd12, 15'd20, 15'd20, 16'd900, 8'd3, 1);
      // point boxes on one spot give a negative union, so both stay
      send_box(16'sd0, 16'sd0, 15'd0, 15'd0, 16'd7, 8'd4, 0);
      send_box(16'sd0, 16'sd0, 15'd0, 15'd0, 16'd7, 8'd5, 1);
      // apart point boxes: zero union and zero overlap
      send_box(16'sd100, 16'sd100, 15'd0, 15'd0, 16'd0, 8'd0, 0);
      send_box(-16'sd100, 16'sd100, 15'd0, 15'd0, 16'd0, 8'd6, 1);
      // opposite corners, full size boxes
      send_box(16'sd32767, -16'sd32768, 15'd32767, 15'd32767, 16'd0, 8'd0, 0);
      send_box(-16'sd32768, 16'sd32767, 15'd32767, 15'd32767, 16'hFFFF, 8'hAA, 0);
      send_box(16'sd0, 16'sd0, 15'd32767, 15'd32767, 16'h5555, 8'h55, 1);

      // phases: each sets a threshold and an idling mode
      for (int phase = 0; phase < 8; phase++) begin
         int target;
         case (phase)
            0: write_threshold(8'd0);
            1: write_threshold(8'd255);
            2: write_threshold(8'd128);
            3: write_threshold(8'd64);
            default: write_threshold(8'($urandom_range(0, 255)));
         endcase
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 57; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         // over-capacity set: the last box is dropped but still starts the pass
         if (phase == 0) send_set(66);
         target = boxes_sent + 42;
         while (boxes_sent < target) begin
            send_set($urandom_range(0, 7) == 0 ? $urandom_range(9, 16)
                                                : $urandom_range(1, 8));
            // long receiver hold while boxes keep coming
            if (phase == 2 && hold_ticket == 0) hold_ticket++;
            if ($urandom_range(0, 9) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("ran %0d boxes in %0d sets, %0d survivors, four idling modes",
               boxes_sent, sets_sent, survivors_seen);
      $display("thresholds 0, 64, 128, 255 and random; one set over capacity");
      if (fail_count == 0 && survivors_due == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d survivors never seen", fail_count, survivors_due);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
